// ===== hw/rtl/cmr_pkg.sv =====
// Shared constants and codes for the colormap ramp sampler.
package cmr_pkg;

  localparam int LUT_SIZE_DEF    = 256;
  localparam int MAX_ANCHORS_DEF = 16;

  localparam int VALUE_W    = 20;
  localparam int IDX_W      = 4;
  localparam int CHAN_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int STEPS_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS        = 2'd2;

endpackage

// ===== hw/rtl/cmr_if.sv =====
// Channel interfaces of the colormap ramp sampler: sample/write words, results, config.
interface cmr_sample_if import cmr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [VALUE_W-1:0] value_t;
  logic [IDX_W-1:0]          anchor_index;
  logic [CHAN_W-1:0]         anchor_red;
  logic [CHAN_W-1:0]         anchor_green;
  logic [CHAN_W-1:0]         anchor_blue;

  modport source (output valid, req_type, value_t, anchor_index, anchor_red, anchor_green,
                  anchor_blue, input ready);
  modport sink (input valid, req_type, value_t, anchor_index, anchor_red, anchor_green,
                anchor_blue, output ready);
endinterface

interface cmr_result_if import cmr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface cmr_cfg_if import cmr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cmr_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module cmr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== hw/rtl/cmr_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, shared divisor across lanes.
module cmr_divider #(
  parameter int DEN_W = 8,
  parameter int QUO_W = 8,
  parameter int LANES = 1,
  parameter int PAY_W = 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [LANES-1:0][DEN_W+QUO_W-1:0]      num_i,
  input  logic [DEN_W-1:0]                       den_i,
  input  logic [PAY_W-1:0]                       pay_i,
  output logic                                   valid_o,
  output logic [LANES-1:0][QUO_W-1:0]            quo_o,
  output logic [LANES-1:0][DEN_W-1:0]            rem_o,
  output logic [PAY_W-1:0]                       pay_o
);

  logic [QUO_W-1:0]                  v_q;
  logic [LANES-1:0][DEN_W-1:0]       r_q   [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]       r_d   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]       lo_q  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]       lo_d  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]       q_q   [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]       q_d   [QUO_W];
  logic [DEN_W-1:0]                  den_q [QUO_W];
  logic [PAY_W-1:0]                  pay_q [QUO_W];
  logic [LANES-1:0][DEN_W-1:0]       r_in  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]       lo_in [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]       q_in  [QUO_W];
  logic [DEN_W-1:0]                  den_in [QUO_W];
  logic [QUO_W:0]                    v_ext;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      r_in[0][l]  = num_i[l][DEN_W+QUO_W-1:QUO_W];
      lo_in[0][l] = num_i[l][QUO_W-1:0];
      q_in[0][l]  = '0;
    end
    den_in[0] = den_i;
    for (int s = 1; s < QUO_W; s++) begin
      r_in[s]   = r_q[s-1];
      lo_in[s]  = lo_q[s-1];
      q_in[s]   = q_q[s-1];
      den_in[s] = den_q[s-1];
    end
  end

  always_comb begin
    logic [DEN_W:0] rs;
    logic           ge;
    for (int s = 0; s < QUO_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rs = {r_in[s][l], lo_in[s][l][QUO_W-1]};
        ge = (rs >= {1'b0, den_in[s]});
        if (ge) begin
          r_d[s][l] = DEN_W'(rs - {1'b0, den_in[s]});
        end else begin
          r_d[s][l] = DEN_W'(rs);
        end
        lo_d[s][l] = lo_in[s][l] << 1;
        q_d[s][l]  = (q_in[s][l] << 1) | QUO_W'(ge);
      end
    end
  end

  assign v_ext = {v_q, valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_ext[QUO_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q[0] <= pay_i;
      for (int s = 1; s < QUO_W; s++) begin
        pay_q[s] <= pay_q[s-1];
      end
      for (int s = 0; s < QUO_W; s++) begin
        r_q[s]   <= r_d[s];
        lo_q[s]  <= lo_d[s];
        q_q[s]   <= q_d[s];
        den_q[s] <= den_in[s];
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = q_q[QUO_W-1];
  assign rem_o   = r_q[QUO_W-1];
  assign pay_o   = pay_q[QUO_W-1];

endmodule

// ===== hw/rtl/colormap_ramp_sampler.sv =====
// Colormap ramp sampler: maps a Q3.16 position to RGB through a ramp of anchor colors.
// Throughput: one word per cycle; a two-entry output buffer holds results while the sink stalls,
// and the pipeline holds only while that buffer is full.
// Divisions by LUT_SIZE-1 take two stages each; the band center division takes one per bit.
// Reset clears the config registers and all valid bits; the anchor RAM is not cleared.
module colormap_ramp_sampler import cmr_pkg::*; #(
  parameter int LUT_SIZE    = LUT_SIZE_DEF,
  parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  cmr_sample_if.sink   sample_i,
  cmr_result_if.source result_o,
  cmr_cfg_if.sink      cfg_i
);

  localparam int JW    = $clog2(LUT_SIZE);
  localparam int MW    = $clog2(MAX_ANCHORS);
  localparam int CW    = MW + 1;
  localparam int POS_W = 17;
  localparam int PW    = CHAN_W + JW;
  localparam int BN_W  = JW + STEPS_W;
  localparam int AN_W  = JW + MW;
  localparam logic [JW-1:0] DV = JW'(LUT_SIZE - 1);
  localparam logic [BN_W:0] RCP_BN = (BN_W+1)'((64'd1 << BN_W) / (LUT_SIZE - 1));
  localparam logic [AN_W:0] RCP_AN = (AN_W+1)'((64'd1 << AN_W) / (LUT_SIZE - 1));
  localparam logic [PW:0]   RCP_SM = (PW+1)'((64'd1 << PW) / (LUT_SIZE - 1));

  typedef struct packed {
    logic                   is_wr;
    logic [IDX_W-1:0]       idx;
    logic [2:0][CHAN_W-1:0] rgb;
  } item_t;

  typedef struct packed {
    item_t         item;
    logic [JW-1:0] j;
  } item_j_t;

  // config
  logic [COUNT_W-1:0] cfg_count_q;
  logic               cfg_rev_q;
  logic [STEPS_W-1:0] cfg_steps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= '0;
      cfg_rev_q   <= 1'b0;
      cfg_steps_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ANCHOR_COUNT: cfg_count_q <= cfg_i.data[COUNT_W-1:0];
        CFG_REVERSE:      cfg_rev_q   <= cfg_i.data[0];
        CFG_STEPS:        cfg_steps_q <= cfg_i.data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0]      cnt;
  logic [MW-1:0]      last;
  logic               few_anchors;
  logic               black;
  logic [STEPS_W-1:0] nm1;
  logic               few_steps;

  always_comb begin
    if (32'(cfg_count_q) > MAX_ANCHORS) begin
      cnt = CW'(MAX_ANCHORS);
    end else begin
      cnt = CW'(cfg_count_q);
    end
    few_anchors = (cnt < CW'(2));
    black       = (cnt == '0);
    last        = few_anchors ? '0 : MW'(cnt - CW'(1));
    nm1         = cfg_steps_q - STEPS_W'(1);
    few_steps   = (cfg_steps_q < STEPS_W'(2));
  end

  // pipeline advance and output buffer state
  logic       en;
  logic [1:0] ocnt_q;

  assign en             = (ocnt_q != 2'd2);
  assign sample_i.ready = en;

  // s0: input register
  logic                      s0_v_q;
  item_t                     s0_item_q;
  logic signed [VALUE_W-1:0] s0_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_item_q.is_wr  <= (sample_i.req_type == REQ_WRITE);
      s0_item_q.idx    <= sample_i.anchor_index;
      s0_item_q.rgb    <= {sample_i.anchor_red, sample_i.anchor_green, sample_i.anchor_blue};
      s0_t_q           <= sample_i.value_t;
    end
  end

  // s1: clamp and scale to table index
  logic [POS_W-1:0]    pos;
  logic [POS_W+JW-1:0] pos_prod;
  logic                s1_v_q;
  item_t               s1_item_q;
  logic [JW-1:0]       s1_j_q;

  always_comb begin
    if (s0_t_q[VALUE_W-1] || (s0_t_q == '0)) begin
      pos = '0;
    end else if (s0_t_q[VALUE_W-2:16] != '0) begin
      pos = POS_W'(17'h10000);
    end else begin
      pos = {1'b0, s0_t_q[15:0]};
    end
    pos_prod = (POS_W+JW)'(pos) * (POS_W+JW)'(DV);
  end

  // s2: band numerator
  logic                   s2_v_q;
  item_j_t                s2_pay_q;
  logic [BN_W-1:0]        s2_num_q;

  // band division: reciprocal estimate, then one correction step
  logic                   bq_v_q;
  item_j_t                bq_pay_q;
  logic [BN_W-1:0]        bq_num_q;
  logic [BN_W-1:0]        bq_est_q;
  logic                   bc_v_q;
  item_j_t                bc_pay_q;
  logic [STEPS_W-1:0]     bc_band_q;
  logic [2*BN_W:0]        bn_prod;
  logic [BN_W-1:0]        bn_rem;
  logic                   bn_up;

  always_comb begin
    bn_prod = (2*BN_W+1)'(s2_num_q) * (2*BN_W+1)'(RCP_BN);
    bn_rem  = bq_num_q - bq_est_q * BN_W'(DV);
    bn_up   = (bn_rem >= BN_W'(DV));
  end

  // s3: band clamp and center numerator
  logic [STEPS_W-1:0]     band;
  logic                   s3_v_q;
  item_j_t                s3_pay_q;
  logic [STEPS_W+JW-1:0]  s3_num_q;
  logic [STEPS_W-1:0]     s3_den_q;

  always_comb begin
    if (few_steps) begin
      band = '0;
    end else if (bc_band_q > nm1) begin
      band = nm1;
    end else begin
      band = bc_band_q;
    end
  end

  // s4: index select and mirror
  logic          b_v;
  logic [JW-1:0] b_quo;
  item_j_t       b_pay;
  logic [JW-1:0] j_sel;
  logic [JW-1:0] j_fin;
  logic          s4_v_q;
  item_t         s4_item_q;
  logic [JW-1:0] s4_j_q;

  always_comb begin
    if (cfg_steps_q == '0) begin
      j_sel = b_pay.j;
    end else if (few_steps) begin
      j_sel = DV >> 1;
    end else begin
      j_sel = b_quo;
    end
    j_fin = cfg_rev_q ? (DV - j_sel) : j_sel;
  end

  // s5: anchor numerator
  logic             s5_v_q;
  item_t            s5_item_q;
  logic [AN_W-1:0]  s5_num_q;

  // anchor division: reciprocal estimate, then one correction step
  logic             aq_v_q;
  item_t            aq_item_q;
  logic [AN_W-1:0]  aq_num_q;
  logic [AN_W-1:0]  aq_est_q;
  logic             ac_v_q;
  item_t            ac_item_q;
  logic [MW-1:0]    ac_quo_q;
  logic [JW-1:0]    ac_rem_q;
  logic [2*AN_W:0]  an_prod;
  logic [AN_W-1:0]  an_rem;
  logic             an_up;

  always_comb begin
    an_prod = (2*AN_W+1)'(s5_num_q) * (2*AN_W+1)'(RCP_AN);
    an_rem  = aq_num_q - aq_est_q * AN_W'(DV);
    an_up   = (an_rem >= AN_W'(DV));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      bq_v_q <= 1'b0;
      bc_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      aq_v_q <= 1'b0;
      ac_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      bq_v_q <= s2_v_q;
      bc_v_q <= bq_v_q;
      s3_v_q <= bc_v_q;
      s4_v_q <= b_v;
      s5_v_q <= s4_v_q;
      aq_v_q <= s5_v_q;
      ac_v_q <= aq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_item_q     <= s0_item_q;
      s1_j_q        <= JW'(pos_prod >> 16);
      s2_pay_q.item <= s1_item_q;
      s2_pay_q.j    <= s1_j_q;
      s2_num_q      <= BN_W'(s1_j_q) * BN_W'(cfg_steps_q);
      bq_pay_q      <= s2_pay_q;
      bq_num_q      <= s2_num_q;
      bq_est_q      <= BN_W'(bn_prod >> BN_W);
      bc_pay_q      <= bq_pay_q;
      bc_band_q     <= STEPS_W'(bq_est_q + BN_W'(bn_up));
      s3_pay_q      <= bc_pay_q;
      s3_num_q      <= (STEPS_W+JW)'(band) * (STEPS_W+JW)'(DV);
      s3_den_q      <= few_steps ? STEPS_W'(1) : nm1;
      s4_item_q     <= b_pay.item;
      s4_j_q        <= j_fin;
      s5_item_q     <= s4_item_q;
      s5_num_q      <= AN_W'(s4_j_q) * AN_W'(last);
      aq_item_q     <= s5_item_q;
      aq_num_q      <= s5_num_q;
      aq_est_q      <= AN_W'(an_prod >> AN_W);
      ac_item_q     <= aq_item_q;
      ac_quo_q      <= MW'(aq_est_q + AN_W'(an_up));
      ac_rem_q      <= JW'(an_up ? an_rem - AN_W'(DV) : an_rem);
    end
  end

  cmr_divider #(
    .DEN_W (STEPS_W),
    .QUO_W (JW),
    .LANES (1),
    .PAY_W ($bits(item_j_t))
  ) u_div_center (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .num_i   (s3_num_q),
    .den_i   (s3_den_q),
    .pay_i   (s3_pay_q),
    .valid_o (b_v),
    .quo_o   (b_quo),
    .rem_o   (),
    .pay_o   (b_pay)
  );

  // s6: anchor pair select, RAM access
  logic [MW-1:0]          seg;
  logic [JW-1:0]          frac;
  logic                   ram_we;
  logic [2:0][CHAN_W-1:0] rd_lo;
  logic [2:0][CHAN_W-1:0] rd_hi;
  logic                   s6_v_q;
  logic                   s6_black_q;
  logic [JW-1:0]          s6_rem_q;

  always_comb begin
    if (few_anchors) begin
      seg  = '0;
      frac = '0;
    end else if (ac_quo_q == last) begin
      seg  = last - MW'(1);
      frac = DV;
    end else begin
      seg  = ac_quo_q;
      frac = ac_rem_q;
    end
    ram_we = en && ac_v_q && ac_item_q.is_wr && (32'(ac_item_q.idx) < MAX_ANCHORS);
  end

  cmr_ram #(
    .WIDTH (3 * CHAN_W),
    .DEPTH (MAX_ANCHORS)
  ) u_anchor_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (MW'(ac_item_q.idx)),
    .wdata_i   (ac_item_q.rgb),
    .re_i      (en),
    .raddr_a_i (seg),
    .raddr_b_i (seg + MW'(1)),
    .rdata_a_o (rd_lo),
    .rdata_b_o (rd_hi)
  );

  // s7: blend products; s8: rounded sum
  logic [2:0][PW-1:0] pa;
  logic [2:0][PW-1:0] pb;
  logic               s7_v_q;
  logic               s7_black_q;
  logic [2:0][PW-1:0] s7_pa_q;
  logic [2:0][PW-1:0] s7_pb_q;
  logic               s8_v_q;
  logic               s8_black_q;
  logic [2:0][PW-1:0] s8_sum_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pa[ch] = PW'(rd_lo[ch]) * PW'(DV - s6_rem_q);
      pb[ch] = (s6_rem_q == '0) ? '0 : PW'(rd_hi[ch]) * PW'(s6_rem_q);
    end
  end

  // blend division: reciprocal estimate, then one correction step
  logic                   dq_v_q;
  logic                   dq_black_q;
  logic [2:0][PW-1:0]     dq_sum_q;
  logic [2:0][PW-1:0]     dq_est_q;
  logic                   dc_v_q;
  logic                   dc_black_q;
  logic [2:0][CHAN_W-1:0] dc_quo_q;
  logic [2:0][2*PW:0]     sm_prod;
  logic [2:0][PW-1:0]     sm_rem;
  logic [2:0]             sm_up;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sm_prod[ch] = (2*PW+1)'(s8_sum_q[ch]) * (2*PW+1)'(RCP_SM);
      sm_rem[ch]  = dq_sum_q[ch] - dq_est_q[ch] * PW'(DV);
      sm_up[ch]   = (sm_rem[ch] >= PW'(DV));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
      s8_v_q <= 1'b0;
      dq_v_q <= 1'b0;
      dc_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= ac_v_q && !ac_item_q.is_wr;
      s7_v_q <= s6_v_q;
      s8_v_q <= s7_v_q;
      dq_v_q <= s8_v_q;
      dc_v_q <= dq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_black_q <= black;
      s6_rem_q   <= frac;
      s7_black_q <= s6_black_q;
      s7_pa_q    <= pa;
      s7_pb_q    <= pb;
      s8_black_q <= s7_black_q;
      dq_black_q <= s8_black_q;
      dq_sum_q   <= s8_sum_q;
      dc_black_q <= dq_black_q;
      for (int ch = 0; ch < 3; ch++) begin
        s8_sum_q[ch] <= s7_pa_q[ch] + s7_pb_q[ch] + PW'(DV >> 1);
        dq_est_q[ch] <= PW'(sm_prod[ch] >> PW);
        dc_quo_q[ch] <= CHAN_W'(dq_est_q[ch] + PW'(sm_up[ch]));
      end
    end
  end

  logic [2:0][CHAN_W-1:0] color;

  assign color = dc_black_q ? '0 : dc_quo_q;

  // output buffer: two entries
  logic [2:0][CHAN_W-1:0] head_q, head_d;
  logic [2:0][CHAN_W-1:0] tail_q, tail_d;
  logic [1:0]             ocnt_d;
  logic                   push;
  logic                   pop;

  assign push = en && dc_v_q;
  assign pop  = result_o.valid && result_o.ready;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    ocnt_d = ocnt_q;
    unique case ({push, pop})
      2'b10: begin
        if (ocnt_q == 2'd0) begin
          head_d = color;
        end else begin
          tail_d = color;
        end
        ocnt_d = ocnt_q + 2'd1;
      end
      2'b01: begin
        head_d = tail_q;
        ocnt_d = ocnt_q - 2'd1;
      end
      2'b11: begin
        head_d = color;
      end
      2'b00: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
    end else begin
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign result_o.valid     = (ocnt_q != 2'd0);
  assign result_o.out_red   = head_q[2];
  assign result_o.out_green = head_q[1];
  assign result_o.out_blue  = head_q[0];

endmodule
